// ----- hw/rtl/als_pkg.sv -----
// Arm launch sequencer package: phase encoding, command and register codes,
// state, configuration and result types. No dependencies.
`default_nettype none

package als_pkg;

  // Sequence phases, one-hot
  typedef enum logic [5:0] {
    PH_IDLE     = 6'b000001,
    PH_SLOW_FWD = 6'b000010,
    PH_SLOW_REV = 6'b000100,
    PH_RAMP     = 6'b001000,
    PH_HOLD     = 6'b010000,
    PH_FAST_REV = 6'b100000
  } phase_e;

  // Command codes carried in func
  localparam logic [1:0] FuncTick   = 2'd0;
  localparam logic [1:0] FuncStart  = 2'd1;
  localparam logic [1:0] FuncCancel = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CfgRampStep   = 3'd0;
  localparam logic [2:0] CfgSlowSpeed  = 3'd1;
  localparam logic [2:0] CfgSlowFwd    = 3'd2;
  localparam logic [2:0] CfgSlowRev    = 3'd3;
  localparam logic [2:0] CfgShotTicks  = 3'd4;
  localparam logic [2:0] CfgFastRev    = 3'd5;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  // Register reset values
  localparam logic [6:0] RstRampStep  = 7'd5;
  localparam logic [6:0] RstSlowSpeed = 7'd30;
  localparam logic [7:0] RstSlowFwd   = 8'd100;
  localparam logic [7:0] RstSlowRev   = 8'd100;
  localparam logic [7:0] RstShotTicks = 8'd100;
  localparam logic [7:0] RstFastRev   = 8'd60;

  localparam logic [6:0] FullPower = 7'd100;

  typedef struct packed {
    logic [6:0] ramp_step;
    logic [6:0] slow_speed;
    logic [7:0] slow_forward_ticks;
    logic [7:0] slow_reverse_ticks;
    logic [7:0] shot_ticks;
    logic [7:0] fast_reverse_ticks;
  } cfg_t;

  typedef struct packed {
    phase_e     phase;
    logic [7:0] tick_count;
    logic [6:0] ramp_power;
    logic [6:0] ramp_iter;
    logic       ramp_clamped;
  } state_t;

  typedef struct packed {
    logic [6:0] drive_power;
    logic       drive_reverse;
    logic       drive_on;
    logic       stopper_engaged;
    logic       busy_res;
  } res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/als_if.sv -----
// Handshake channels of the arm launch sequencer: command item in, result
// item out. Standalone, no package dependency.
`default_nettype none

interface als_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic       slow_mode;

  modport source (output valid, output func, output slow_mode, input ready);
  modport sink   (input valid, input func, input slow_mode, output ready);
endinterface

interface als_res_if;
  logic       valid;
  logic       ready;
  logic [6:0] drive_power;
  logic       drive_reverse;
  logic       drive_on;
  logic       stopper_engaged;
  logic       busy_res;

  modport source (output valid, output drive_power, output drive_reverse,
                  output drive_on, output stopper_engaged, output busy_res,
                  input ready);
  modport sink   (input valid, input drive_power, input drive_reverse,
                  input drive_on, input stopper_engaged, input busy_res,
                  output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/arm_launch_sequencer_core.sv -----
// Arm launch sequencer top level: command register, step logic, result register.
// Throughput: one item per cycle while the result side is ready; a stalled result
// holds the item in the command register and so stalls the command channel.
// The state updates as an item moves from the command register into the result register.
// Reset (rst_ni, async low): phase idle, counters cleared, registers at defaults.
// Depends on als_pkg, als_if, als_cfg_regs, als_step.
`default_nettype none

module arm_launch_sequencer_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  als_cmd_if.sink                            cmd_i,
  als_res_if.source                          res_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [als_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [als_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  als_pkg::cfg_t   cfg;
  als_pkg::state_t state_q, state_d;
  als_pkg::res_t   res_q, res_d;
  logic            cmd_valid_q;
  logic [1:0]      func_q;
  logic            slow_mode_q;
  logic            res_valid_q;
  logic            adv;

  als_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  als_step u_step (
    .cfg_i       (cfg),
    .state_i     (state_q),
    .func_i      (func_q),
    .slow_mode_i (slow_mode_q),
    .state_o     (state_d),
    .res_o       (res_d)
  );

  // item moves from the command register into the result register
  assign adv         = cmd_valid_q && (!res_valid_q || res_o.ready);
  assign cmd_i.ready = !cmd_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
      state_q     <= '{phase: als_pkg::PH_IDLE, tick_count: 8'd0, ramp_power: 7'd0,
                       ramp_iter: 7'd0, ramp_clamped: 1'b0};
    end else begin
      if (cmd_i.ready) begin
        cmd_valid_q <= cmd_i.valid;
      end
      if (adv) begin
        res_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ready && cmd_i.valid) begin
      func_q      <= cmd_i.func;
      slow_mode_q <= cmd_i.slow_mode;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid           = res_valid_q;
  assign res_o.drive_power     = res_q.drive_power;
  assign res_o.drive_reverse   = res_q.drive_reverse;
  assign res_o.drive_on        = res_q.drive_on;
  assign res_o.stopper_engaged = res_q.stopper_engaged;
  assign res_o.busy_res        = res_q.busy_res;

  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q.phase))
    else $error("sequencer phase not one-hot");

  a_idle_count_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == als_pkg::PH_IDLE) |-> (state_q.tick_count == 8'd0))
    else $error("tick count not cleared in idle");

  a_ramp_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.ramp_power <= als_pkg::FullPower)
    else $error("ramp power above full power");

  a_off_is_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_q.drive_on) |->
      (res_q.drive_power == 7'd0 && !res_q.drive_reverse && !res_q.busy_res))
    else $error("stopped motor reports power, direction or busy");

endmodule

`default_nettype wire

// ----- hw/rtl/als_cfg_regs.sv -----
// Configuration register bank of the arm launch sequencer.
// Depends on als_pkg.
`default_nettype none

module als_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [als_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [als_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output als_pkg::cfg_t                      cfg_o
);

  als_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ramp_step          <= als_pkg::RstRampStep;
      cfg_q.slow_speed         <= als_pkg::RstSlowSpeed;
      cfg_q.slow_forward_ticks <= als_pkg::RstSlowFwd;
      cfg_q.slow_reverse_ticks <= als_pkg::RstSlowRev;
      cfg_q.shot_ticks         <= als_pkg::RstShotTicks;
      cfg_q.fast_reverse_ticks <= als_pkg::RstFastRev;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        als_pkg::CfgRampStep:  cfg_q.ramp_step          <= cfg_wdata_i[6:0];
        als_pkg::CfgSlowSpeed: cfg_q.slow_speed         <= cfg_wdata_i[6:0];
        als_pkg::CfgSlowFwd:   cfg_q.slow_forward_ticks <= cfg_wdata_i;
        als_pkg::CfgSlowRev:   cfg_q.slow_reverse_ticks <= cfg_wdata_i;
        als_pkg::CfgShotTicks: cfg_q.shot_ticks         <= cfg_wdata_i;
        als_pkg::CfgFastRev:   cfg_q.fast_reverse_ticks <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- hw/rtl/als_step.sv -----
// Next-state and result logic for one command item of the arm launch
// sequencer. Purely combinational; depends on als_pkg.
`default_nettype none

module als_step (
  input  wire als_pkg::cfg_t   cfg_i,
  input  wire als_pkg::state_t state_i,
  input  wire logic [1:0]      func_i,
  input  wire logic            slow_mode_i,
  output als_pkg::state_t      state_o,
  output als_pkg::res_t        res_o
);

  logic [6:0] step_eff;
  logic [6:0] slow_pw;
  logic [6:0] floor_div;
  logic [7:0] hold_len;
  logic [7:0] tick_inc;
  logic [7:0] ramp_sum;
  logic [7:0] ramp_base;
  logic [6:0] iter_base;
  logic       fast_start;
  als_pkg::phase_e enter_slow_fwd, enter_slow_rev, enter_hold, enter_fast_rev;
  als_pkg::state_t st;

  assign step_eff = (cfg_i.ramp_step == 7'd0) ? 7'd1 : cfg_i.ramp_step;
  assign slow_pw  = (cfg_i.slow_speed > als_pkg::FullPower) ? als_pkg::FullPower
                                                              : cfg_i.slow_speed;

  // floor(100/step) equals ramp iterations minus the final clamp flag
  assign floor_div = (7'(state_i.ramp_clamped) > state_i.ramp_iter) ? 7'd0
                   : state_i.ramp_iter - 7'(state_i.ramp_clamped);
  assign hold_len  = (cfg_i.shot_ticks > {1'b0, floor_div})
                   ? cfg_i.shot_ticks - {1'b0, floor_div} : 8'd0;

  assign tick_inc = state_i.tick_count + 8'd1;

  // Phase entry with zero-length phases skipped
  assign enter_slow_rev = (cfg_i.slow_reverse_ticks == 8'd0) ? als_pkg::PH_IDLE
                                                              : als_pkg::PH_SLOW_REV;
  assign enter_slow_fwd = (cfg_i.slow_forward_ticks == 8'd0) ? enter_slow_rev
                                                              : als_pkg::PH_SLOW_FWD;
  assign enter_fast_rev = (cfg_i.fast_reverse_ticks == 8'd0) ? als_pkg::PH_IDLE
                                                              : als_pkg::PH_FAST_REV;
  assign enter_hold     = (hold_len == 8'd0) ? enter_fast_rev : als_pkg::PH_HOLD;

  // Ramp increment, from zero on a fast start
  assign fast_start = (func_i == als_pkg::FuncStart);
  assign ramp_base  = fast_start ? 8'd0 : {1'b0, state_i.ramp_power};
  assign iter_base  = fast_start ? 7'd0 : state_i.ramp_iter;
  assign ramp_sum   = ramp_base + {1'b0, step_eff};

  always_comb begin
    st = state_i;
    priority if (func_i == als_pkg::FuncStart) begin
      if (state_i.phase == als_pkg::PH_IDLE) begin
        st.tick_count = 8'd0;
        if (slow_mode_i) begin
          st.phase = enter_slow_fwd;
        end else begin
          st.phase        = als_pkg::PH_RAMP;
          st.ramp_clamped = (ramp_sum > {1'b0, als_pkg::FullPower});
          st.ramp_power   = st.ramp_clamped ? als_pkg::FullPower : ramp_sum[6:0];
          st.ramp_iter    = iter_base + 7'd1;
        end
      end
    end else if (func_i == als_pkg::FuncCancel) begin
      st.phase      = als_pkg::PH_IDLE;
      st.tick_count = 8'd0;
    end else if (func_i == als_pkg::FuncTick) begin
      unique case (state_i.phase)
        als_pkg::PH_SLOW_FWD: begin
          st.tick_count = tick_inc;
          if (tick_inc >= cfg_i.slow_forward_ticks) begin
            st.phase      = enter_slow_rev;
            st.tick_count = 8'd0;
          end
        end
        als_pkg::PH_SLOW_REV: begin
          st.tick_count = tick_inc;
          if (tick_inc >= cfg_i.slow_reverse_ticks) begin
            st.phase      = als_pkg::PH_IDLE;
            st.tick_count = 8'd0;
          end
        end
        als_pkg::PH_RAMP: begin
          if (state_i.ramp_power >= als_pkg::FullPower) begin
            st.phase      = enter_hold;
            st.tick_count = 8'd0;
          end else begin
            st.ramp_clamped = (ramp_sum > {1'b0, als_pkg::FullPower});
            st.ramp_power   = st.ramp_clamped ? als_pkg::FullPower : ramp_sum[6:0];
            st.ramp_iter    = iter_base + 7'd1;
          end
        end
        als_pkg::PH_HOLD: begin
          st.tick_count = tick_inc;
          if (tick_inc >= hold_len) begin
            st.phase      = enter_fast_rev;
            st.tick_count = 8'd0;
          end
        end
        als_pkg::PH_FAST_REV: begin
          st.tick_count = tick_inc;
          if (tick_inc >= cfg_i.fast_reverse_ticks) begin
            st.phase      = als_pkg::PH_IDLE;
            st.tick_count = 8'd0;
          end
        end
        default: ;
      endcase
    end else begin
      // unused command code: state unchanged
      st = state_i;
    end
  end

  assign state_o = st;

  always_comb begin
    res_o = '0;
    unique case (st.phase)
      als_pkg::PH_SLOW_FWD: begin
        res_o.drive_power = slow_pw;
        res_o.drive_on    = 1'b1;
      end
      als_pkg::PH_SLOW_REV: begin
        res_o.drive_power   = slow_pw;
        res_o.drive_reverse = 1'b1;
        res_o.drive_on      = 1'b1;
      end
      als_pkg::PH_RAMP: begin
        res_o.drive_power = st.ramp_power;
        res_o.drive_on    = 1'b1;
      end
      als_pkg::PH_HOLD: begin
        res_o.drive_power = als_pkg::FullPower;
        res_o.drive_on    = 1'b1;
      end
      als_pkg::PH_FAST_REV: begin
        res_o.drive_power   = als_pkg::FullPower;
        res_o.drive_reverse = 1'b1;
        res_o.drive_on      = 1'b1;
      end
      default: ;
    endcase
    res_o.busy_res        = (st.phase != als_pkg::PH_IDLE);
    res_o.stopper_engaged = res_o.busy_res;
  end

endmodule

`default_nettype wire

// ----- tb/tb_arm_launch_sequencer_core.sv -----
// Self-checking bench for arm_launch_sequencer_core: a stimulus table followed by
// randomized shot sequences under several register profiles, checked against a
// behavioral sequencer model or fixed row results. Depends on als_pkg, als_if, core RTL.

module tb_arm_launch_sequencer_core;
  import als_pkg::*;

  localparam logic [1:0] FuncUnused = 2'd3;   // undefined command, must be ignored
  localparam logic [2:0] CfgSpare   = 3'd7;   // unmapped register index
  localparam int CycleLimit = 600000;
  localparam int DirRows    = 34;
  localparam res_t Stopped  = '0;

  typedef enum logic {RowItem, RowWrite} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  func;
    logic        slow;
    logic        typed;   // 1: compare against res, 0: against the sequencer model
    res_t        res;
    logic [2:0]  idx;
    logic [7:0]  wdata;
  } dir_row_t;

  // kind      func        slow  typed res                                   idx           wdata
  localparam dir_row_t DirectedPlan [DirRows] = '{
    '{RowItem,  FuncTick,   1'b0, 1'b1, Stopped,                              CfgRampStep,  8'd0},
    '{RowItem,  FuncCancel, 1'b1, 1'b1, Stopped,                              CfgRampStep,  8'd0},
    '{RowItem,  FuncUnused, 1'b1, 1'b1, Stopped,                              CfgRampStep,  8'd0},
    '{RowItem,  FuncStart,  1'b1, 1'b1, '{7'd30, 1'b0, 1'b1, 1'b1, 1'b1},    CfgRampStep,  8'd0},
    '{RowItem,  FuncStart,  1'b0, 1'b1, '{7'd30, 1'b0, 1'b1, 1'b1, 1'b1},    CfgRampStep,  8'd0},
    '{RowItem,  FuncUnused, 1'b0, 1'b0, Stopped,                              CfgRampStep,  8'd0},
    '{RowItem,  FuncTick,   1'b0, 1'b0, Stopped,                              CfgRampStep,  8'd0},
    '{RowItem,  FuncCancel, 1'b0, 1'b1, Stopped,                              CfgRampStep,  8'd0},
    '{RowItem,  FuncStart,  1'b0, 1'b1, '{7'd5, 1'b0, 1'b1, 1'b1, 1'b1},     CfgRampStep,  8'd0},
    '{RowItem,  FuncTick,   1'b1, 1'b0, Stopped,                              CfgRampStep,  8'd0},
    '{RowItem,  FuncCancel, 1'b1, 1'b1, Stopped,                              CfgRampStep,  8'd0},
    // zero step and all durations zero
    '{RowWrite, FuncTick,   1'b0, 1'b0, Stopped,                              CfgRampStep,  8'd0},
    '{RowWrite, FuncTick,   1'b0, 1'b0, Stopped,                              CfgShotTicks, 8'd0},
    '{RowWrite, FuncTick,   1'b0, 1'b0, Stopped,                              CfgFastRev,   8'd0},
    '{RowWrite, FuncTick,   1'b0, 1'b0, Stopped,                              CfgSlowFwd,   8'd0},
    '{RowWrite, FuncTick,   1'b0, 1'b0, Stopped,                              CfgSlowRev,   8'd0},
    '{RowItem,  FuncStart,  1'b0, 1'b1, '{7'd1, 1'b0, 1'b1, 1'b1, 1'b1},     CfgRampStep,  8'd0},
    '{RowItem,  FuncTick,   1'b0, 1'b0, Stopped,                              CfgRampStep,  8'd0},
    '{RowItem,  FuncCancel, 1'b0, 1'b1, Stopped,                              CfgRampStep,  8'd0},
    '{RowItem,  FuncStart,  1'b1, 1'b1, Stopped,                              CfgRampStep,  8'd0},
    // step above full power: first increment clamps, hold and reverse both empty
    '{RowWrite, FuncTick,   1'b0, 1'b0, Stopped,                              CfgRampStep,  8'hFF},
    '{RowItem,  FuncStart,  1'b0, 1'b1, '{7'd100, 1'b0, 1'b1, 1'b1, 1'b1},   CfgRampStep,  8'd0},
    '{RowItem,  FuncTick,   1'b0, 1'b1, Stopped,                              CfgRampStep,  8'd0},
    // slow speed above full power saturates
    '{RowWrite, FuncTick,   1'b0, 1'b0, Stopped,                              CfgSlowSpeed, 8'hFF},
    '{RowWrite, FuncTick,   1'b0, 1'b0, Stopped,                              CfgSlowFwd,   8'd1},
    '{RowWrite, FuncTick,   1'b0, 1'b0, Stopped,                              CfgSlowRev,   8'd2},
    '{RowItem,  FuncStart,  1'b1, 1'b1, '{7'd100, 1'b0, 1'b1, 1'b1, 1'b1},   CfgRampStep,  8'd0},
    '{RowItem,  FuncTick,   1'b1, 1'b1, '{7'd100, 1'b1, 1'b1, 1'b1, 1'b1},   CfgRampStep,  8'd0},
    '{RowItem,  FuncTick,   1'b0, 1'b0, Stopped,                              CfgRampStep,  8'd0},
    '{RowItem,  FuncTick,   1'b0, 1'b1, Stopped,                              CfgRampStep,  8'd0},
    // zero speed, forward skipped straight to reverse
    '{RowWrite, FuncTick,   1'b0, 1'b0, Stopped,                              CfgSlowSpeed, 8'd0},
    '{RowWrite, FuncTick,   1'b0, 1'b0, Stopped,                              CfgSlowFwd,   8'd0},
    '{RowItem,  FuncStart,  1'b1, 1'b1, '{7'd0, 1'b1, 1'b1, 1'b1, 1'b1},     CfgRampStep,  8'd0},
    '{RowItem,  FuncCancel, 1'b0, 1'b1, Stopped,                              CfgRampStep,  8'd0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  als_cmd_if cmd_ch ();
  als_res_if res_ch ();

  arm_launch_sequencer_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_ch),
    .res_o       (res_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Sequencer model state and register copy
  cfg_t   model_cfg;
  state_t seq;
  res_t   expected_drive [$];
  int     mismatches = 0;
  int     cycle_count = 0;
  bit     no_idle;
  int     stall_left = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // floor(100/step) is the ramp count less one when the last increment clamped
  function automatic logic [7:0] hold_ticks();
    int unsigned fl;
    fl = (seq.ramp_clamped > seq.ramp_iter) ? 0 : seq.ramp_iter - seq.ramp_clamped;
    return (model_cfg.shot_ticks > fl) ? 8'(model_cfg.shot_ticks - fl) : 8'd0;
  endfunction

  function automatic void ramp_add();
    int unsigned sum;
    sum = seq.ramp_power + ((model_cfg.ramp_step == 0) ? 1 : model_cfg.ramp_step);
    seq.ramp_clamped = (sum > FullPower);
    seq.ramp_power   = (sum > FullPower) ? FullPower : 7'(sum);
    seq.ramp_iter    = seq.ramp_iter + 7'd1;
  endfunction

  // Zero-length phases fall through; PH_IDLE target finishes the shot
  function automatic void enter_phase(phase_e p);
    if (p == PH_SLOW_FWD && model_cfg.slow_forward_ticks == 0) p = PH_SLOW_REV;
    if (p == PH_SLOW_REV && model_cfg.slow_reverse_ticks == 0) p = PH_IDLE;
    if (p == PH_HOLD && hold_ticks() == 0) p = PH_FAST_REV;
    if (p == PH_FAST_REV && model_cfg.fast_reverse_ticks == 0) p = PH_IDLE;
    seq.phase      = p;
    seq.tick_count = '0;
  endfunction

  function automatic void count_tick(logic [7:0] limit, phase_e next);
    seq.tick_count = seq.tick_count + 8'd1;
    if (seq.tick_count >= limit) enter_phase(next);
  endfunction

  function automatic res_t advance_sequence(logic [1:0] func, logic slow);
    res_t r;
    logic [6:0] slow_pwr;
    case (func)
      FuncStart: begin
        if (seq.phase == PH_IDLE) begin
          if (slow) begin
            enter_phase(PH_SLOW_FWD);
          end else begin
            seq.ramp_power   = '0;
            seq.ramp_iter    = '0;
            seq.ramp_clamped = 1'b0;
            ramp_add();
            enter_phase(PH_RAMP);
          end
        end
      end
      FuncCancel: begin
        if (seq.phase != PH_IDLE) enter_phase(PH_IDLE);
      end
      FuncTick: begin
        case (seq.phase)
          PH_SLOW_FWD: count_tick(model_cfg.slow_forward_ticks, PH_SLOW_REV);
          PH_SLOW_REV: count_tick(model_cfg.slow_reverse_ticks, PH_IDLE);
          PH_RAMP: begin
            if (seq.ramp_power >= FullPower) enter_phase(PH_HOLD);
            else ramp_add();
          end
          PH_HOLD:     count_tick(hold_ticks(), PH_FAST_REV);
          PH_FAST_REV: count_tick(model_cfg.fast_reverse_ticks, PH_IDLE);
          default: ;
        endcase
      end
      default: ;
    endcase

    slow_pwr = (model_cfg.slow_speed > FullPower) ? FullPower : model_cfg.slow_speed;
    r = '0;
    case (seq.phase)
      PH_SLOW_FWD: begin r.drive_power = slow_pwr; r.drive_on = 1'b1; end
      PH_SLOW_REV: begin
        r.drive_power = slow_pwr; r.drive_reverse = 1'b1; r.drive_on = 1'b1;
      end
      PH_RAMP:     begin r.drive_power = seq.ramp_power; r.drive_on = 1'b1; end
      PH_HOLD:     begin r.drive_power = FullPower; r.drive_on = 1'b1; end
      PH_FAST_REV: begin
        r.drive_power = FullPower; r.drive_reverse = 1'b1; r.drive_on = 1'b1;
      end
      default: ;
    endcase
    r.stopper_engaged = (seq.phase != PH_IDLE);
    r.busy_res        = (seq.phase != PH_IDLE);
    return r;
  endfunction

  task automatic send_cmd(input logic [1:0] func, input logic slow, input logic typed,
                          input res_t want);
    int gap;
    res_t predicted;
    gap = no_idle ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      cmd_ch.valid = 1'b0;
    end
    @(negedge clk_i);
    cmd_ch.valid     = 1'b1;
    cmd_ch.func      = func;
    cmd_ch.slow_mode = slow;
    do @(posedge clk_i); while (!cmd_ch.ready);
    predicted = advance_sequence(func, slow);
    expected_drive.push_back(typed ? want : predicted);
  endtask

  // Stop sending and let every outstanding result come back
  task automatic drain_results();
    @(negedge clk_i);
    cmd_ch.valid = 1'b0;
    while (expected_drive.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
    @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = data;
    case (idx)
      CfgRampStep:  model_cfg.ramp_step          = data[6:0];
      CfgSlowSpeed: model_cfg.slow_speed         = data[6:0];
      CfgSlowFwd:   model_cfg.slow_forward_ticks = data;
      CfgSlowRev:   model_cfg.slow_reverse_ticks = data;
      CfgShotTicks: model_cfg.shot_ticks         = data;
      CfgFastRev:   model_cfg.fast_reverse_ticks = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic load_profile(input logic [7:0] step, input logic [7:0] speed,
                              input logic [7:0] fwd, input logic [7:0] rev,
                              input logic [7:0] shot, input logic [7:0] frev);
    drain_results();
    write_reg(CfgRampStep, step);
    write_reg(CfgSlowSpeed, speed);
    write_reg(CfgSlowFwd, fwd);
    write_reg(CfgSlowRev, rev);
    write_reg(CfgShotTicks, shot);
    write_reg(CfgFastRev, frev);
    write_reg(CfgSpare, 8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] rand_ticks();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'd0;
    if (r < 90) return 8'($urandom_range(1, 12));
    return 8'($urandom_range(13, 255));
  endfunction

  // Mostly starts when stopped and ticks when running; only items that change
  // something count toward the target.
  task automatic run_items(input int target, input int cancel_pct);
    int done_cnt;
    int r;
    bit stopped;
    logic [1:0] func;
    logic slow;
    done_cnt = 0;
    while (done_cnt < target) begin
      stopped = (seq.phase == PH_IDLE);
      r = $urandom_range(0, 99);
      slow = 1'($urandom_range(0, 1));
      if (stopped) begin
        func = (r < 75) ? FuncStart : (r < 85) ? FuncTick : (r < 93) ? FuncCancel : FuncUnused;
      end else begin
        func = (r < cancel_pct) ? FuncCancel :
               (r < cancel_pct + 3) ? FuncStart :
               (r < cancel_pct + 6) ? FuncUnused : FuncTick;
      end
      if ((stopped && func == FuncStart) ||
          (!stopped && (func == FuncTick || func == FuncCancel))) done_cnt++;
      send_cmd(func, slow, 1'b0, Stopped);
    end
  endtask

  // Result side: random back-pressure, always ready while no_idle is set
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      res_ch.ready = 1'b0;
    end else if (no_idle) begin
      res_ch.ready = 1'b1;
    end else if (stall_left > 0) begin
      res_ch.ready = 1'b0;
      stall_left--;
    end else begin
      res_ch.ready = 1'b1;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk_i) begin : check_results
    res_t got;
    res_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got = '{res_ch.drive_power, res_ch.drive_reverse, res_ch.drive_on,
              res_ch.stopper_engaged, res_ch.busy_res};
      if (expected_drive.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result item: pwr=%0d rev=%0b on=%0b stop=%0b busy=%0b",
                   got.drive_power, got.drive_reverse, got.drive_on,
                   got.stopper_engaged, got.busy_res);
      end else begin
        want = expected_drive.pop_front();
        if (got.drive_power !== want.drive_power || got.drive_reverse !== want.drive_reverse ||
            got.drive_on !== want.drive_on || got.stopper_engaged !== want.stopper_engaged ||
            got.busy_res !== want.busy_res) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result mismatch: expected pwr=%0d rev=%0b on=%0b stop=%0b busy=%0b,",
                      " got pwr=%0d rev=%0b on=%0b stop=%0b busy=%0b"},
                     want.drive_power, want.drive_reverse, want.drive_on,
                     want.stopper_engaged, want.busy_res,
                     got.drive_power, got.drive_reverse, got.drive_on,
                     got.stopper_engaged, got.busy_res);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t row;
    bit prev_write;
    logic [7:0] step_v, speed_v;
    cmd_ch.valid     = 1'b0;
    cmd_ch.func      = FuncTick;
    cmd_ch.slow_mode = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = CfgRampStep;
    cfg_wdata        = '0;
    rst_ni           = 1'b0;
    no_idle          = 1'b0;
    model_cfg = '{RstRampStep, RstSlowSpeed, RstSlowFwd, RstSlowRev, RstShotTicks, RstFastRev};
    seq       = '{PH_IDLE, 8'd0, 7'd0, 7'd0, 1'b0};
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    prev_write = 1'b0;
    for (int i = 0; i < DirRows; i++) begin
      row = DirectedPlan[i];
      if (row.kind == RowWrite) begin
        if (!prev_write) drain_results();
        write_reg(row.idx, row.wdata);
      end else begin
        send_cmd(row.func, row.slow, row.typed, row.res);
      end
      prev_write = (row.kind == RowWrite);
    end

    for (int p = 0; p < 8; p++) begin
      no_idle = (p % 3 == 2);
      case (p)
        0: load_profile(8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        1: load_profile(8'd100, 8'd100, 8'd255, 8'd255, 8'd255, 8'd255);
        default: begin
          step_v  = ($urandom_range(0, 99) < 20) ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(10, 100));
          speed_v = 8'($urandom_range(0, 255));
          load_profile(step_v, speed_v, rand_ticks(), rand_ticks(),
                       8'($urandom_range(0, 15)), rand_ticks());
        end
      endcase
      if (p == 1) begin
        run_items(450, 0);
      end else if (p == 3) begin
        run_items(75, 3);
        drain_results();
        run_items(75, 3);
      end else begin
        run_items(150, 3);
      end
    end

    drain_results();
    repeat (6) @(posedge clk_i);
    if (mismatches == 0 && expected_drive.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/als_pkg.sv
hw/rtl/als_if.sv
hw/rtl/als_cfg_regs.sv
hw/rtl/als_step.sv
hw/rtl/arm_launch_sequencer_core.sv
tb/tb_arm_launch_sequencer_core.sv
